/* rtl/sps_pkg.sv */
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, command codes and the coil step table of the stepper phase
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

	// Command bytes (ASCII).
	localparam logic [7:0] CMD_START   = 8'h30;
	localparam logic [7:0] CMD_STOP    = 8'h31;
	localparam logic [7:0] CMD_REVERSE = 8'h32;
	localparam logic [7:0] CMD_SLOWER  = 8'h71;
	localparam logic [7:0] CMD_FASTER  = 8'h77;
	localparam logic [7:0] CMD_WAVE    = 8'h61;
	localparam logic [7:0] CMD_FULL    = 8'h73;
	localparam logic [7:0] CMD_HALF    = 8'h64;
	localparam logic [7:0] CMD_ROTATE  = 8'h66;

	// Result codes reported for each beat.
	localparam logic [3:0] RES_NONE    = 4'd0;
	localparam logic [3:0] RES_START   = 4'd1;
	localparam logic [3:0] RES_STOP    = 4'd2;
	localparam logic [3:0] RES_REVERSE = 4'd3;
	localparam logic [3:0] RES_SLOWER  = 4'd4;
	localparam logic [3:0] RES_FASTER  = 4'd5;
	localparam logic [3:0] RES_WAVE    = 4'd6;
	localparam logic [3:0] RES_FULL    = 4'd7;
	localparam logic [3:0] RES_HALF    = 4'd8;
	localparam logic [3:0] RES_ROTATE  = 4'd9;

	// Drive modes and sequence kinds.
	localparam logic [2:0] DM_IDLE     = 3'd0;
	localparam logic [2:0] DM_WAVE     = 3'd1;
	localparam logic [2:0] DM_FULL     = 3'd2;
	localparam logic [2:0] DM_HALF     = 3'd3;
	localparam logic [2:0] DM_ROTATION = 3'd4;

	// Item type: a tick or a command byte.
	localparam logic ITEM_TICK    = 1'b0;
	localparam logic ITEM_COMMAND = 1'b1;

	// Configuration register indexes.
	localparam logic REG_SPEED_INCREMENT = 1'b0;
	localparam logic REG_SPEED_LIMIT     = 1'b1;

	// Reset values.
	localparam logic [7:0]  SPEED_INCREMENT_RESET = 8'd10;
	localparam logic [15:0] SPEED_LIMIT_RESET     = 16'd500;
	localparam int          STEP_PERIOD_RESET     = 100;

	typedef struct packed {
		logic       kind;
		logic [7:0] cmd;
	} item_t;

	typedef struct packed {
		logic [3:0]  coils;
		logic        step_taken;
		logic [3:0]  code;
		logic [15:0] period;
	} result_t;

	// Coil patterns, bit order 1a,1b,2a,2b.
	function automatic logic [3:0] coil_lookup(input logic [2:0] idx);
		logic [3:0] pat;
		unique case (idx)
			3'd0: pat = 4'b1000;
			3'd1: pat = 4'b1010;
			3'd2: pat = 4'b0010;
			3'd3: pat = 4'b0110;
			3'd4: pat = 4'b0100;
			3'd5: pat = 4'b0101;
			3'd6: pat = 4'b0001;
			default: pat = 4'b1001;
		endcase
		return pat;
	endfunction

	// Position within a sequence to table index. Half step walks all eight
	// entries, full step the odd ones, wave and rotation the even ones.
	function automatic logic [2:0] table_index(input logic [2:0] kind, input logic cw,
			input logic [2:0] pos);
		logic [2:0] idx;
		if (kind == DM_HALF) begin
			idx = cw ? pos : (3'd7 - pos);
		end else if (kind == DM_FULL) begin
			idx = cw ? {pos[1:0], 1'b1} : (3'd7 - {pos[1:0], 1'b0});
		end else begin
			idx = cw ? {pos[1:0], 1'b0} : (3'd6 - {pos[1:0], 1'b0});
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

/* rtl/sps_engine.sv */
// ----------------------------------------------------------------------------
// sps_engine
// Sequencer state and its one-beat update: command decode, period control
// and the tick-driven coil stepping.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_engine #(
	parameter int ROTATION_SEQUENCES = 12,
	parameter int PERIOD_WIDTH       = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire sps_pkg::item_t  item,
	input  wire logic [7:0]      speed_increment,
	input  wire logic [15:0]     speed_limit,
	output sps_pkg::result_t     result
);
	import sps_pkg::*;

	localparam logic [3:0] ROT_COUNT = 4'(ROTATION_SEQUENCES);

	logic                    run_q, run_d;
	logic                    cw_q, cw_d;
	logic [2:0]              mode_q, mode_d;
	logic [PERIOD_WIDTH-1:0] per_q, per_d;
	logic [PERIOD_WIDTH-1:0] wait_q, wait_d;
	logic [2:0]              pos_q, pos_d;
	logic [2:0]              kind_q, kind_d;
	logic                    dir_q, dir_d;
	logic [3:0]              rot_q, rot_d;
	logic [3:0]              pat_q, pat_d;

	logic                    wait_go;
	logic                    step_go;
	logic                    rot_mid;
	logic [3:0]              code;
	logic [31:0]             lim_wide;
	logic [PERIOD_WIDTH-1:0] lim;
	logic [PERIOD_WIDTH-1:0] inc;
	logic [PERIOD_WIDTH:0]   sum;
	logic [31:0]             per_wide;

	// The limit is clipped to the period width.
	assign lim_wide = {16'd0, speed_limit};
	assign lim      = lim_wide[PERIOD_WIDTH-1:0];
	assign inc      = PERIOD_WIDTH'(speed_increment);
	assign sum      = {1'b0, per_q} + {1'b0, inc};

	always_comb begin
		run_d   = run_q;
		cw_d    = cw_q;
		mode_d  = mode_q;
		per_d   = per_q;
		wait_d  = wait_q;
		pos_d   = pos_q;
		kind_d  = kind_q;
		dir_d   = dir_q;
		rot_d   = rot_q;
		pat_d   = pat_q;
		code    = RES_NONE;
		wait_go = 1'b0;
		step_go = 1'b0;
		rot_mid = 1'b0;
		if (item.kind == ITEM_COMMAND) begin
			unique case (item.cmd)
				CMD_START: begin
					run_d = 1'b1;
					code  = RES_START;
				end
				CMD_STOP: begin
					run_d = 1'b0;
					code  = RES_STOP;
				end
				CMD_REVERSE: begin
					cw_d = ~cw_q;
					code = RES_REVERSE;
				end
				CMD_SLOWER: begin
					if (per_q < lim) begin
						per_d = (sum > {1'b0, lim}) ? lim : sum[PERIOD_WIDTH-1:0];
					end
					code = RES_SLOWER;
				end
				CMD_FASTER: begin
					if (per_q != '0) begin
						per_d = (per_q > inc) ? (per_q - inc) : '0;
					end
					code = RES_FASTER;
				end
				CMD_WAVE: begin
					mode_d = DM_WAVE;
					code   = RES_WAVE;
				end
				CMD_FULL: begin
					mode_d = DM_FULL;
					code   = RES_FULL;
				end
				CMD_HALF: begin
					mode_d = DM_HALF;
					code   = RES_HALF;
				end
				CMD_ROTATE: begin
					mode_d = DM_ROTATION;
					code   = RES_ROTATE;
				end
				default: code = RES_NONE;
			endcase
		end else begin
			wait_go = 1'b1;
			if (wait_q != '0) begin
				wait_d = wait_q - 1'b1;
				if (wait_d != '0) begin
					wait_go = 1'b0;
				end
			end
			if (wait_go) begin
				step_go = 1'b1;
				if (pos_q == 3'd0) begin
					rot_mid = (kind_q == DM_ROTATION) && (rot_q != 4'd0) && (rot_q < ROT_COUNT);
					if (!rot_mid) begin
						// A finished rotation falls back to idle.
						if ((kind_q == DM_ROTATION) && (rot_q >= ROT_COUNT)) begin
							mode_d = DM_IDLE;
						end
						kind_d = DM_IDLE;
						rot_d  = 4'd0;
						if (!run_q || (mode_d < DM_WAVE) || (mode_d > DM_ROTATION)) begin
							step_go = 1'b0;
						end else begin
							kind_d = mode_d;
							dir_d  = cw_q;
						end
					end
				end
				if (step_go) begin
					pat_d = coil_lookup(table_index(kind_d, dir_d, pos_q));
					if (kind_d == DM_HALF) begin
						pos_d = pos_q + 3'd1;
					end else begin
						pos_d = {1'b0, pos_q[1:0] + 2'd1};
					end
					if ((pos_d == 3'd0) && (kind_d == DM_ROTATION)) begin
						rot_d = rot_d + 4'd1;
					end
					wait_d = (per_q == '0) ? PERIOD_WIDTH'(1) : per_q;
				end
			end
		end
	end

	assign per_wide          = 32'(per_d);
	assign result.coils      = pat_d;
	assign result.step_taken = step_go;
	assign result.code       = code;
	assign result.period     = per_wide[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b1;
			cw_q   <= 1'b1;
			mode_q <= DM_IDLE;
			per_q  <= PERIOD_WIDTH'(STEP_PERIOD_RESET);
			wait_q <= '0;
			pos_q  <= 3'd0;
			kind_q <= DM_IDLE;
			dir_q  <= 1'b1;
			rot_q  <= 4'd0;
			pat_q  <= 4'd0;
		end else if (fire) begin
			run_q  <= run_d;
			cw_q   <= cw_d;
			mode_q <= mode_d;
			per_q  <= per_d;
			wait_q <= wait_d;
			pos_q  <= pos_d;
			kind_q <= kind_d;
			dir_q  <= dir_d;
			rot_q  <= rot_d;
			pat_q  <= pat_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/stepper_phase_sequencer_top.sv */
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_top
// Flow: a beat accepted into the input register has its result loaded into
// the result register when the engine fires, which waits while the output
// stalls.
// Throughput: one beat per cycle unless the output stalls; the state update
// is a single pass of short logic between the input and result registers.
// Reset: arst_n clears all control and sequencer state asynchronously.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_phase_sequencer_top #(
	parameter int ROTATION_SEQUENCES = 12,
	parameter int PERIOD_WIDTH       = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [7:0]  command_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             coil_1a,
	output logic             coil_1b,
	output logic             coil_2a,
	output logic             coil_2b,
	output logic             step_taken,
	output logic [3:0]       command_result,
	output logic [15:0]      period_now
);
	import sps_pkg::*;

	logic [7:0]  speed_increment_q;
	logic [15:0] speed_limit_q;

	logic    valid_s1;
	item_t   item_s1;
	logic    adv_s1;
	logic    fire;
	result_t result_d;
	result_t result_q;
	logic    out_valid_q;

	// Config writes land at once; users must write only while idle, unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_increment_q <= SPEED_INCREMENT_RESET;
			speed_limit_q     <= SPEED_LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SPEED_INCREMENT: speed_increment_q <= cfg_data[7:0];
				REG_SPEED_LIMIT:     speed_limit_q     <= cfg_data;
				default:             speed_limit_q     <= speed_limit_q;
			endcase
		end
	end

	// The input stage moves on whenever the result register is empty or is
	// being drained this cycle. Because of that, a new beat can be taken
	// while a finished result is still waiting in the result register.
	assign adv_s1   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_s1;
	assign fire     = valid_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind <= mode;
			item_s1.cmd  <= command_byte;
		end
	end

	// The engine holds all sequencer state and commits its update on fire.
	sps_engine #(
		.ROTATION_SEQUENCES(ROTATION_SEQUENCES),
		.PERIOD_WIDTH      (PERIOD_WIDTH)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.item           (item_s1),
		.speed_increment(speed_increment_q),
		.speed_limit    (speed_limit_q),
		.result         (result_d)
	);

	// Result register. It is reloaded when the engine fires and is emptied
	// when the consumer takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign coil_1a        = result_q.coils[3];
	assign coil_1b        = result_q.coils[2];
	assign coil_2a        = result_q.coils[1];
	assign coil_2b        = result_q.coils[0];
	assign step_taken     = result_q.step_taken;
	assign command_result = result_q.code;
	assign period_now     = result_q.period;

	// A step is only ever taken on a tick, so a command code never comes
	// with a step.
	a_step_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item_s1.kind == ITEM_COMMAND) |-> !result_d.step_taken)
		else $error("step taken on a command beat");

	// Ticks never report a command code.
	a_tick_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item_s1.kind == ITEM_TICK) |-> (result_d.code == RES_NONE))
		else $error("command code reported on a tick beat");

	// A beat held in the input stage is not dropped while the output stalls.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a stalled beat");

	// A waiting result stays until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(result_q))
		else $error("result register changed while stalled");

endmodule

`default_nettype wire

/* tb/stepper_phase_sequencer_top_tb.sv */
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_top_tb
// Self-checking bench for the stepper phase sequencer. Ticks and command
// bytes go in over a valid/ready channel. A cycle-free predictor of the coil
// sequencer works out the coil pattern, step flag, command code and period
// for every accepted beat. Each returned beat is compared field by field
// against the oldest prediction. Runs directed corner cases first, then
// random phases under several register settings and idle patterns.
// ----------------------------------------------------------------------------

module stepper_phase_sequencer_top_tb;

	import sps_pkg::*;

	localparam int ROT_SEQS      = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int RUN_LIMIT     = 400000;
	localparam int SETTLE_CYCLES = 8;

	// Coil patterns by step slot, slot 0 in the low nibble (bits 1a,1b,2a,2b).
	localparam logic [31:0] COIL_STEPS = {4'b1001, 4'b0001, 4'b0101, 4'b0100,
		4'b0110, 4'b0010, 4'b1010, 4'b1000};

	localparam logic [7:0] COMMAND_SET [9] = '{CMD_START, CMD_STOP, CMD_REVERSE,
		CMD_SLOWER, CMD_FASTER, CMD_WAVE, CMD_FULL, CMD_HALF, CMD_ROTATE};

	// Settings of the random phases.
	localparam int PHASES = 8;
	localparam int PHASE_INC   [PHASES] = '{1, 2, 255, 255, 3, 1, 7, 1};
	localparam int PHASE_LIM   [PHASES] = '{4, 9, 65535, 0, 6, 2, 30, 1};
	localparam int PHASE_IDLE  [PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3};
	localparam int PHASE_ITEMS [PHASES] = '{60, 50, 25, 50, 60, 50, 50, 55};

	// Tracks the sequencer state and holds the predicted beats in order.
	class phase_tracker;
		logic [7:0]  increment;
		logic [15:0] limit;
		bit          running;
		bit          clockwise;
		bit          direction;
		logic [2:0]  drive;
		logic [2:0]  kind;
		logic [2:0]  position;
		logic [15:0] period;
		logic [15:0] wait_left;
		logic [3:0]  rotations;
		logic [3:0]  coils;
		result_t     pending_beats[$];
		int          faults;

		function new();
			increment = SPEED_INCREMENT_RESET;
			limit = SPEED_LIMIT_RESET;
			running = 1'b1;
			clockwise = 1'b1;
			direction = 1'b1;
			drive = DM_IDLE;
			kind = DM_IDLE;
			position = '0;
			period = 16'(STEP_PERIOD_RESET);
			wait_left = '0;
			rotations = '0;
			coils = '0;
			faults = 0;
		endfunction

		function void write_reg(logic idx, logic [15:0] data);
			if (idx == REG_SPEED_INCREMENT) begin
				increment = data[7:0];
			end else begin
				limit = data;
			end
		endfunction

		function logic [2:0] step_slot();
			int k;
			k = int'(position[1:0]);
			if (kind == DM_HALF) begin
				return direction ? position : 3'(7 - int'(position));
			end
			if (kind == DM_FULL) begin
				return direction ? 3'(2 * k + 1) : 3'(7 - 2 * k);
			end
			return direction ? 3'(2 * k) : 3'(6 - 2 * k);
		endfunction

		// Returns 1 when the tick drives a new pattern.
		function bit advance_tick();
			bit mid_rotation;
			int len;
			if (wait_left != 0) begin
				wait_left--;
				if (wait_left != 0) return 1'b0;
			end
			if (position == 0) begin
				mid_rotation = (kind == DM_ROTATION) && (rotations > 0) &&
					(rotations < ROT_SEQS);
				if (!mid_rotation) begin
					// A finished rotation drops the mode back to idle,
					// overriding any mode command that came during its wait.
					if (kind == DM_ROTATION && rotations >= ROT_SEQS) drive = DM_IDLE;
					kind = DM_IDLE;
					rotations = '0;
					if (!running || drive < DM_WAVE || drive > DM_ROTATION) return 1'b0;
					kind = drive;
					direction = clockwise;
				end
			end
			coils = COIL_STEPS[int'(step_slot()) * 4 +: 4];
			len = (kind == DM_HALF) ? 8 : 4;
			position = 3'((int'(position) + 1) % len);
			if (position == 0 && kind == DM_ROTATION) rotations++;
			wait_left = (period == 0) ? 16'd1 : period;
			return 1'b1;
		endfunction

		function logic [3:0] apply_command(logic [7:0] b);
			int sum;
			case (b)
				CMD_START: begin
					running = 1'b1;
					return RES_START;
				end
				CMD_STOP: begin
					running = 1'b0;
					return RES_STOP;
				end
				CMD_REVERSE: begin
					clockwise = !clockwise;
					return RES_REVERSE;
				end
				CMD_SLOWER: begin
					// At or above the limit the period stays put.
					if (period < limit) begin
						sum = int'(period) + int'(increment);
						period = (sum > int'(limit)) ? limit : 16'(sum);
					end
					return RES_SLOWER;
				end
				CMD_FASTER: begin
					if (period > 0) period = (period > increment) ? period - increment : '0;
					return RES_FASTER;
				end
				CMD_WAVE: begin
					drive = DM_WAVE;
					return RES_WAVE;
				end
				CMD_FULL: begin
					drive = DM_FULL;
					return RES_FULL;
				end
				CMD_HALF: begin
					drive = DM_HALF;
					return RES_HALF;
				end
				CMD_ROTATE: begin
					drive = DM_ROTATION;
					return RES_ROTATE;
				end
				default: return RES_NONE;
			endcase
		endfunction

		function void note_item(logic m, logic [7:0] b);
			result_t r;
			r.step_taken = 1'b0;
			r.code = RES_NONE;
			if (m == ITEM_COMMAND) begin
				r.code = apply_command(b);
			end else begin
				r.step_taken = advance_tick();
			end
			r.coils = coils;
			r.period = period;
			pending_beats.push_back(r);
		endfunction

		function void report(string field, logic [15:0] want, logic [15:0] got);
			faults++;
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
		endfunction

		function void check_beat(result_t got);
			result_t want;
			if (pending_beats.size() == 0) begin
				faults++;
				$display("%0t: result beat with nothing expected", $time);
				return;
			end
			want = pending_beats.pop_front();
			for (int i = 0; i < 4; i++) begin
				if (got.coils[3 - i] !== want.coils[3 - i]) begin
					report($sformatf("coil_%0d%s", 1 + i / 2, (i % 2) ? "b" : "a"),
						16'(want.coils[3 - i]), 16'(got.coils[3 - i]));
				end
			end
			if (got.step_taken !== want.step_taken) begin
				report("step_taken", 16'(want.step_taken), 16'(got.step_taken));
			end
			if (got.code !== want.code) report("command_result", 16'(want.code), 16'(got.code));
			if (got.period !== want.period) report("period_now", want.period, got.period);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic        cfg_index = REG_SPEED_INCREMENT;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        mode = ITEM_TICK;
	logic [7:0]  command_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        coil_1a;
	logic        coil_1b;
	logic        coil_2a;
	logic        coil_2b;
	logic        step_taken;
	logic [3:0]  command_result;
	logic [15:0] period_now;

	// Percent of cycles the sender idles and the receiver stalls.
	int gap_pct = 0;
	int stall_pct = 0;

	// The stimulus bumps hold_asks to request one long receiver hold-off;
	// the receiver counts the hold-off down on its own.
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	phase_tracker tracker = new();

	stepper_phase_sequencer_top #(
		.ROTATION_SEQUENCES(ROT_SEQS),
		.PERIOD_WIDTH(16)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.command_byte(command_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.coil_1a(coil_1a),
		.coil_1b(coil_1b),
		.coil_2a(coil_2a),
		.coil_2b(coil_2b),
		.step_taken(step_taken),
		.command_result(command_result),
		.period_now(period_now)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver side. Outputs are sampled at the rising edge, so they still
	// hold the values from before the edge. A beat that completes here is
	// checked against the oldest prediction, then out_ready is chosen for
	// the next cycle: held low during a hold-off, random otherwise.
	always @(posedge clk) begin : result_side
		result_t seen;
		if (out_valid && out_ready) begin
			seen.coils = {coil_1a, coil_1b, coil_2a, coil_2b};
			seen.step_taken = step_taken;
			seen.code = command_result;
			seen.period = period_now;
			tracker.check_beat(seen);
		end
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Offers one beat and returns at the edge where it is accepted. Valid
	// stays high on return, so back-to-back beats never drop it.
	// Random idle cycles are inserted before the beat at gap_pct percent.
	task automatic send_item(input logic m, input logic [7:0] b);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		command_byte <= b;
		do @(posedge clk); while (!in_ready);
		tracker.note_item(m, b);
	endtask

	task automatic send_command(input logic [7:0] b);
		send_item(ITEM_COMMAND, b);
	endtask

	// Ticks carry a random byte, which the block must ignore.
	task automatic send_tick();
		send_item(ITEM_TICK, 8'($urandom_range(0, 255)));
	endtask

	// Waits until every predicted beat has come back, then lets the
	// two-stage pipeline settle before any register write.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending_beats.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		tracker.write_reg(idx, data);
	endtask

	// One random beat: mostly ticks and recognized commands, with a little
	// noise from arbitrary bytes. Noise does not count toward the total.
	task automatic pick_item(output logic m, output logic [7:0] b, output bit counted);
		int r;
		r = $urandom_range(0, 99);
		counted = 1'b1;
		if (r < 50) begin
			m = ITEM_TICK;
			b = 8'($urandom_range(0, 255));
		end else if (r < 95) begin
			m = ITEM_COMMAND;
			b = COMMAND_SET[$urandom_range(0, 8)];
		end else begin
			m = ITEM_COMMAND;
			b = 8'($urandom_range(0, 255));
			counted = 1'b0;
		end
	endtask

	initial begin : stimulus
		int  done;
		int  burst;
		logic m;
		logic [7:0] b;
		bit  counted;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings. A tick right after reset
		// finds the sequencer idle and must leave the coils off; bytes at
		// both ends of the range are not commands.
		send_item(ITEM_TICK, 8'hFF);
		send_command(8'h00);
		send_command(8'hFF);
		send_command(CMD_SLOWER);
		send_command(CMD_FASTER);
		// Stopped at a boundary: no step even with a mode picked.
		send_command(CMD_STOP);
		send_command(CMD_WAVE);
		send_tick();
		send_command(CMD_START);
		// Reversing twice is still reported each time.
		send_command(CMD_REVERSE);
		send_command(CMD_REVERSE);
		drain();

		// Largest increment and a limit just above the period: the first
		// slower command saturates at the limit, the second finds it reached.
		// Faster then hits zero and stays there, so every tick steps.
		write_reg(REG_SPEED_INCREMENT, 16'd255);
		write_reg(REG_SPEED_LIMIT, 16'd105);
		send_command(CMD_SLOWER);
		send_command(CMD_SLOWER);
		send_command(CMD_FASTER);
		send_command(CMD_FASTER);
		repeat (4) send_tick();
		send_command(CMD_FULL);
		repeat (3) send_tick();
		send_command(CMD_HALF);
		repeat (5) send_tick();
		send_command(CMD_ROTATE);
		repeat (4) send_tick();
		drain();

		// Random phases, each with its own register settings and idle
		// pattern. Phase 6 also holds the receiver off for a long stretch
		// while the sender keeps offering, so the block backs up.
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_SPEED_INCREMENT, 16'(PHASE_INC[p]));
			write_reg(REG_SPEED_LIMIT, 16'(PHASE_LIM[p]));
			@(posedge clk);
			gap_pct = (PHASE_IDLE[p] == 1) ? 74 : (PHASE_IDLE[p] == 3) ? 30 : 0;
			stall_pct <= (PHASE_IDLE[p] == 2) ? 74 : (PHASE_IDLE[p] == 3) ? 30 : 0;
			if (p == 6) hold_asks <= hold_asks + 1;
			done = 0;
			while (done < PHASE_ITEMS[p]) begin
				if ($urandom_range(0, 3) == 0) begin
					// A run of ticks lets sequences and rotations complete.
					burst = $urandom_range(4, 20);
					repeat (burst) send_tick();
					done += burst;
				end else begin
					pick_item(m, b, counted);
					send_item(m, b);
					if (counted) done++;
				end
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.faults == 0 && tracker.pending_beats.size() == 0) begin
			$display("stepper_phase_sequencer_top: match");
		end else begin
			$display("stepper_phase_sequencer_top: mismatch");
		end
		$finish;
	end

	// Watchdog: well beyond the slowest legal run, including all stalls.
	initial begin
		#RUN_LIMIT;
		$display("stepper_phase_sequencer_top: mismatch");
		$finish;
	end

endmodule
